/* sv/mpr_pkg.sv */
// mpr_pkg: shared types and constants of the message-to-publish reframer
// used by every module of the block; depends on nothing
package mpr_pkg;

   localparam int PREFIX_BYTES = 4;
   localparam int PLEN_BYTES   = 4;
   localparam int SUBJ_LIMIT   = 256;
   localparam int QUEUE_DEPTH  = 4;
   localparam int CMD_BYTES    = 4;

   // parse phases, one-hot
   typedef enum logic [9:0] {
      PH_PRE  = 10'b00_0000_0001,
      PH_SHI  = 10'b00_0000_0010,
      PH_SLO  = 10'b00_0000_0100,
      PH_SUBJ = 10'b00_0000_1000,
      PH_HHI  = 10'b00_0001_0000,
      PH_HLO  = 10'b00_0010_0000,
      PH_HDR  = 10'b00_0100_0000,
      PH_PLEN = 10'b00_1000_0000,
      PH_PAY  = 10'b01_0000_0000,
      PH_DONE = 10'b10_0000_0000
   } phase_type;

   // work handed from the parser to the emitter: up to four bytes and frame status
   typedef struct packed {
      logic [2:0]                 count;
      logic [CMD_BYTES-1:0][7:0]  data;
      logic                       last;
      logic                       err;
      logic                       hdrs;
   } cmd_type;

endpackage

/* sv/mpr_req_if.sv */
// mpr_req_if: input byte channel of the reframer (valid/ready handshake)
// standalone; carries one frame byte per transaction
interface mpr_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] in_byte;
   logic       in_last;

   modport source (output valid, output in_byte, output in_last, input ready);
   modport sink   (input valid, input in_byte, input in_last, output ready);
endinterface

/* sv/mpr_rsp_if.sv */
// mpr_rsp_if: result channel of the reframer (valid/ready handshake)
// standalone; carries one rewritten byte or a status-only result per transaction
interface mpr_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_byte;
   logic       out_valid;
   logic       out_last;
   logic       frame_error;
   logic       has_headers;

   modport source (output valid, output out_byte, output out_valid, output out_last,
                   output frame_error, output has_headers, input ready);
   modport sink   (input valid, input out_byte, input out_valid, input out_last,
                   input frame_error, input has_headers, output ready);
endinterface

/* sv/mpr_front.sv */
// mpr_front: frame parser, turns one input byte per cycle (unless q_full) into at most one command
// depends on mpr_pkg and mpr_req_if
module mpr_front (
   input  logic              clock,
   input  logic              reset,
   mpr_req_if.sink           req,
   input  logic              q_full,
   output logic              q_push,
   output mpr_pkg::cmd_type  q_cmd
);
   import mpr_pkg::*;

   phase_type   phase_ff, phase_in;
   logic [31:0] rem_ff, rem_in;
   logic [31:0] len_ff, len_in;
   logic        err_ff, err_in;
   logic        hdr_ff, hdr_in;

   logic        accept;
   logic [7:0]  b;
   logic [15:0] v16;
   logic [31:0] rem_dec;
   logic [31:0] len_shift;
   logic        rem_one;
   logic [2:0]  cnt;
   logic [CMD_BYTES-1:0][7:0] data;
   logic        err_fin;

   assign req.ready = !q_full;
   assign accept    = req.valid && req.ready;
   assign b         = req.in_byte;
   assign v16       = {len_ff[7:0], b};
   assign rem_dec   = rem_ff - 32'd1;
   assign rem_one   = (rem_ff == 32'd1);
   assign len_shift = {len_ff[23:0], b};

   always_comb begin
      phase_in = phase_ff;
      rem_in   = rem_ff;
      len_in   = len_ff;
      err_in   = err_ff;
      hdr_in   = hdr_ff;
      cnt      = 3'd0;
      data     = '0;
      if (!err_ff) begin
         case (phase_ff)
            PH_PRE: begin
               rem_in = rem_dec;
               if (rem_one) phase_in = PH_SHI;
            end
            PH_SHI: begin
               len_in   = {24'd0, b};
               phase_in = PH_SLO;
            end
            PH_SLO: begin
               if (v16 == 16'd0 || v16 >= 16'(SUBJ_LIMIT)) begin
                  err_in = 1'b1;
               end else begin
                  data[0]  = v16[15:8];
                  data[1]  = v16[7:0];
                  cnt      = 3'd2;
                  rem_in   = {16'd0, v16};
                  phase_in = PH_SUBJ;
               end
            end
            PH_SUBJ: begin
               data[0] = b;
               cnt     = 3'd1;
               rem_in  = rem_dec;
               if (rem_one) phase_in = PH_HHI;
            end
            PH_HHI: begin
               len_in   = {24'd0, b};
               phase_in = PH_HLO;
            end
            PH_HLO: begin
               cnt = 3'd2;
               if (v16 != 16'd0) begin
                  data[2]  = v16[15:8];
                  data[3]  = v16[7:0];
                  cnt      = 3'd4;
                  hdr_in   = 1'b1;
                  rem_in   = {16'd0, v16};
                  phase_in = PH_HDR;
               end else begin
                  rem_in   = 32'(PLEN_BYTES);
                  len_in   = 32'd0;
                  phase_in = PH_PLEN;
               end
            end
            PH_HDR: begin
               data[0] = b;
               cnt     = 3'd1;
               rem_in  = rem_dec;
               if (rem_one) begin
                  rem_in   = 32'(PLEN_BYTES);
                  len_in   = 32'd0;
                  phase_in = PH_PLEN;
               end
            end
            PH_PLEN: begin
               len_in = len_shift;
               rem_in = rem_dec;
               if (rem_one) begin
                  if (len_shift == 32'd0) begin
                     phase_in = PH_DONE;
                  end else begin
                     rem_in   = len_shift;
                     phase_in = PH_PAY;
                  end
               end
            end
            PH_PAY: begin
               data[0] = b;
               cnt     = 3'd1;
               rem_in  = rem_dec;
               if (rem_one) phase_in = PH_DONE;
            end
            default: begin
               // byte after the payload is complete
               err_in = 1'b1;
            end
         endcase
      end
   end

   // a short frame is caught at its final byte
   assign err_fin = err_in || (phase_in != PH_DONE);

   assign q_push     = accept && ((cnt != 3'd0) || req.in_last);
   assign q_cmd.count = cnt;
   assign q_cmd.data  = data;
   assign q_cmd.last  = req.in_last;
   assign q_cmd.err   = req.in_last && err_fin;
   assign q_cmd.hdrs  = req.in_last && hdr_in && !err_fin;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_PRE;
         rem_ff   <= 32'(PREFIX_BYTES);
         len_ff   <= 32'd0;
         err_ff   <= 1'b0;
         hdr_ff   <= 1'b0;
      end else if (accept) begin
         if (req.in_last) begin
            phase_ff <= PH_PRE;
            rem_ff   <= 32'(PREFIX_BYTES);
            len_ff   <= 32'd0;
            err_ff   <= 1'b0;
            hdr_ff   <= 1'b0;
         end else begin
            phase_ff <= phase_in;
            rem_ff   <= rem_in;
            len_ff   <= len_in;
            err_ff   <= err_in;
            hdr_ff   <= hdr_in;
         end
      end
   end

endmodule

/* sv/mpr_queue.sv */
// mpr_queue: short command queue between the parser and the emitter
// depends on mpr_pkg
module mpr_queue #(
   parameter int Depth = mpr_pkg::QUEUE_DEPTH
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  mpr_pkg::cmd_type  push_cmd,
   input  logic              pop,
   output mpr_pkg::cmd_type  head_cmd,
   output logic              full,
   output logic              empty
);
   import mpr_pkg::*;

   localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
   localparam int CntW = $clog2(Depth + 1);

   cmd_type             entry_ff [Depth];
   logic [PtrW-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0]     count_ff, count_in;
   logic                do_push, do_pop;

   assign full     = (count_ff == CntW'(Depth));
   assign empty    = (count_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign head_cmd = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PtrW'(Depth - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PtrW'(Depth - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) count_in = count_ff + 1'b1;
      else if (do_pop && !do_push) count_in = count_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) entry_ff[wr_ptr_ff] <= push_cmd;
   end

endmodule

/* sv/mpr_back.sv */
// mpr_back: emitter, walks the bytes of each command into the output register
// depends on mpr_pkg and mpr_rsp_if
module mpr_back (
   input  logic              clock,
   input  logic              reset,
   input  mpr_pkg::cmd_type  head_cmd,
   input  logic              q_empty,
   output logic              q_pop,
   mpr_rsp_if.source         rsp
);
   import mpr_pkg::*;

   logic [1:0] idx_ff, idx_in;
   logic       valid_ff;
   logic [7:0] byte_ff;
   logic       dvalid_ff;
   logic       last_ff;
   logic       err_ff;
   logic       hdrs_ff;

   logic       load;
   logic       take;
   logic       final_byte;
   logic [1:0] last_idx;

   assign load     = !valid_ff || rsp.ready;
   assign take     = load && !q_empty;
   assign last_idx = (head_cmd.count == 3'd0) ? 2'd0 : 2'(head_cmd.count - 3'd1);
   assign final_byte = (idx_ff == last_idx);
   assign q_pop    = take && final_byte;
   assign idx_in   = final_byte ? 2'd0 : idx_ff + 2'd1;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         idx_ff   <= 2'd0;
      end else if (load) begin
         valid_ff <= !q_empty;
         if (take) idx_ff <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         // a command with no bytes is a status-only transaction
         dvalid_ff <= (head_cmd.count != 3'd0);
         byte_ff   <= (head_cmd.count != 3'd0) ? head_cmd.data[idx_ff] : 8'd0;
         last_ff   <= head_cmd.last && final_byte;
         err_ff    <= head_cmd.err && final_byte;
         hdrs_ff   <= head_cmd.hdrs && final_byte;
      end
   end

   assign rsp.valid       = valid_ff;
   assign rsp.out_byte    = byte_ff;
   assign rsp.out_valid   = dvalid_ff;
   assign rsp.out_last    = last_ff;
   assign rsp.frame_error = err_ff;
   assign rsp.has_headers = hdrs_ff;

endmodule

/* sv/message_to_publish_reframer.sv */
// message_to_publish_reframer: top level, rewrites a message frame into publish layout
// depends on mpr_pkg, mpr_req_if, mpr_rsp_if, mpr_front, mpr_queue, mpr_back
//
//   channel  direction  payload                                             
//   req_if   in         in_byte, in_last                                    
//   rsp_if   out        out_byte, out_valid, out_last, frame_error, has_headers
//
// one input byte per cycle unless req_if.ready is low; its results leave one per cycle
// through the output register while rsp_if.ready is high; bytes that open a subject or
// header block give two or four results, so the emitter falls behind there and the
// command queue fills; req_if.ready drops only when it is full; synchronous reset returns
// the parser to the prefix phase and empties queue and output
module message_to_publish_reframer #(
   parameter int QueueDepth = mpr_pkg::QUEUE_DEPTH
) (
   input  logic      clock,
   input  logic      reset,
   mpr_req_if.sink   req_if,
   mpr_rsp_if.source rsp_if
);
   import mpr_pkg::*;

   cmd_type push_cmd;
   cmd_type head_cmd;
   logic    q_push, q_pop, q_full, q_empty;

   mpr_front u_front (
      .clock  (clock),
      .reset  (reset),
      .req    (req_if),
      .q_full (q_full),
      .q_push (q_push),
      .q_cmd  (push_cmd)
   );

   mpr_queue #(
      .Depth (QueueDepth)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (q_push),
      .push_cmd (push_cmd),
      .pop      (q_pop),
      .head_cmd (head_cmd),
      .full     (q_full),
      .empty    (q_empty)
   );

   mpr_back u_back (
      .clock    (clock),
      .reset    (reset),
      .head_cmd (head_cmd),
      .q_empty  (q_empty),
      .q_pop    (q_pop),
      .rsp      (rsp_if)
   );

endmodule

/* bench/tb_message_to_publish_reframer.sv */
// tb_message_to_publish_reframer: self-checking bench for the message-to-publish reframer
// depends on mpr_pkg, mpr_req_if, mpr_rsp_if and message_to_publish_reframer
// frames go in byte by byte, an in-bench predictor builds the publish layout and checks it
`timescale 1ns / 100ps

module tb_message_to_publish_reframer;
   import mpr_pkg::*;

   localparam int STALL_LIMIT  = 2000;
   localparam int BYTES_PER_PHASE = 28;

   typedef struct packed {
      logic [7:0] b;
      logic       last;
   } frame_byte_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       out_valid;
      logic       out_last;
      logic       frame_error;
      logic       has_headers;
   } publish_beat_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   mpr_req_if req_if ();
   mpr_rsp_if rsp_if ();

   message_to_publish_reframer i_dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_if),
      .rsp_if (rsp_if)
   );

   always #10 clock = ~clock;

   frame_byte_type   pending_bytes[$];
   publish_beat_type expected_publish[$];
   logic [7:0]       frame_buf[$];

   int sender_idle_pct = 0;
   int rsp_stall_pct   = 0;
   int fail_count      = 0;
   int bytes_queued    = 0;
   int bytes_in        = 0;
   int beats_checked   = 0;
   int frames_ok       = 0;
   int frames_bad      = 0;
   int stall_cycles    = 0;

   // predictor state
   phase_type   parse_phase;
   logic [31:0] field_left;
   logic [31:0] len_acc;
   bit          err_seen;
   bit          hdrs_seen;

   function automatic void reset_parser();
      parse_phase = PH_PRE;
      field_left  = 32'(PREFIX_BYTES);
      len_acc     = '0;
      err_seen    = 1'b0;
      hdrs_seen   = 1'b0;
   endfunction

   function automatic publish_beat_type data_beat(logic [7:0] b);
      publish_beat_type r;
      r           = '0;
      r.out_byte  = b;
      r.out_valid = 1'b1;
      return r;
   endfunction

   // one input byte in, its publish-layout beats appended to the expectation store
   function automatic void reframe_byte(logic [7:0] b, logic last);
      publish_beat_type step_beats[$];
      publish_beat_type r;
      logic [15:0]      v;
      if (!err_seen) begin
         case (parse_phase)
            PH_PRE: begin
               field_left--;
               if (field_left == 0) parse_phase = PH_SHI;
            end
            PH_SHI: begin
               len_acc     = {24'd0, b};
               parse_phase = PH_SLO;
            end
            PH_SLO: begin
               v = {len_acc[7:0], b};
               if (v == 0 || v >= SUBJ_LIMIT) begin
                  err_seen = 1'b1;
               end else begin
                  step_beats.push_back(data_beat(v[15:8]));
                  step_beats.push_back(data_beat(v[7:0]));
                  field_left  = {16'd0, v};
                  parse_phase = PH_SUBJ;
               end
            end
            PH_SUBJ: begin
               step_beats.push_back(data_beat(b));
               field_left--;
               if (field_left == 0) parse_phase = PH_HHI;
            end
            PH_HHI: begin
               len_acc     = {24'd0, b};
               parse_phase = PH_HLO;
            end
            PH_HLO: begin
               v = {len_acc[7:0], b};
               step_beats.push_back(data_beat(8'd0));
               step_beats.push_back(data_beat(8'd0));
               if (v != 0) begin
                  step_beats.push_back(data_beat(v[15:8]));
                  step_beats.push_back(data_beat(v[7:0]));
                  hdrs_seen   = 1'b1;
                  field_left  = {16'd0, v};
                  parse_phase = PH_HDR;
               end else begin
                  field_left  = 32'(PLEN_BYTES);
                  len_acc     = '0;
                  parse_phase = PH_PLEN;
               end
            end
            PH_HDR: begin
               step_beats.push_back(data_beat(b));
               field_left--;
               if (field_left == 0) begin
                  field_left  = 32'(PLEN_BYTES);
                  len_acc     = '0;
                  parse_phase = PH_PLEN;
               end
            end
            PH_PLEN: begin
               len_acc = {len_acc[23:0], b};
               field_left--;
               if (field_left == 0) begin
                  if (len_acc == 0) begin
                     parse_phase = PH_DONE;
                  end else begin
                     field_left  = len_acc;
                     parse_phase = PH_PAY;
                  end
               end
            end
            PH_PAY: begin
               step_beats.push_back(data_beat(b));
               field_left--;
               if (field_left == 0) parse_phase = PH_DONE;
            end
            default: begin
               // any byte once the payload is complete
               err_seen = 1'b1;
            end
         endcase
      end
      if (last) begin
         if (!err_seen && parse_phase != PH_DONE) err_seen = 1'b1;
         // status rides on the final data beat, or on a status-only beat
         if (step_beats.size() == 0) r = '0;
         else r = step_beats.pop_back();
         r.out_last    = 1'b1;
         r.frame_error = err_seen;
         r.has_headers = hdrs_seen && !err_seen;
         step_beats.push_back(r);
         if (err_seen) frames_bad++;
         else frames_ok++;
         reset_parser();
      end
      foreach (step_beats[i]) expected_publish.push_back(step_beats[i]);
   endfunction

   function automatic void check_field(string name, int exp_val, int act_val);
      if (exp_val != act_val) begin
         $error("%s: expected %0h, actual %0h", name, exp_val, act_val);
         fail_count++;
      end
   endfunction

   // driver
   always @(posedge clock) begin
      frame_byte_type nb;
      if (reset) begin
         req_if.valid   <= 1'b0;
         req_if.in_byte <= 8'd0;
         req_if.in_last <= 1'b0;
      end else begin
         if (req_if.valid && req_if.ready) begin
            reframe_byte(req_if.in_byte, req_if.in_last);
            bytes_in++;
         end
         if (!(req_if.valid && !req_if.ready)) begin
            if (pending_bytes.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
               nb = pending_bytes.pop_front();
               req_if.valid   <= 1'b1;
               req_if.in_byte <= nb.b;
               req_if.in_last <= nb.last;
            end else begin
               req_if.valid <= 1'b0;
            end
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      publish_beat_type exp_beat;
      if (reset) begin
         rsp_if.ready <= 1'b0;
      end else begin
         if (rsp_if.valid && rsp_if.ready) begin
            if (expected_publish.size() == 0) begin
               $error("unexpected transaction: out_byte %0h out_last %0b",
                      rsp_if.out_byte, rsp_if.out_last);
               fail_count++;
            end else begin
               exp_beat = expected_publish.pop_front();
               check_field("out_byte", exp_beat.out_byte, rsp_if.out_byte);
               check_field("out_valid", exp_beat.out_valid, rsp_if.out_valid);
               check_field("out_last", exp_beat.out_last, rsp_if.out_last);
               check_field("frame_error", exp_beat.frame_error, rsp_if.frame_error);
               check_field("has_headers", exp_beat.has_headers, rsp_if.has_headers);
               beats_checked++;
            end
         end
         rsp_if.ready <= ($urandom_range(99) >= rsp_stall_pct);
      end
   end

   // watchdog on cycles without any transaction
   always @(posedge clock) begin
      if (reset || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
         stall_cycles <= 0;
      end else if (stall_cycles >= STALL_LIMIT) begin
         $display("timeout after %0d idle cycles", stall_cycles);
         $display("CHECK FAILED");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   task automatic rand_bytes(int count);
      repeat (count) frame_buf.push_back(8'($urandom));
   endtask

   // move the assembled frame to the driver, in_last on its final byte
   task automatic commit_frame();
      frame_byte_type fb;
      foreach (frame_buf[i]) begin
         fb.b    = frame_buf[i];
         fb.last = (i == frame_buf.size() - 1);
         pending_bytes.push_back(fb);
      end
      bytes_queued += frame_buf.size();
      frame_buf.delete();
   endtask

   task automatic build_frame(bit long_subject);
      int          kind;
      int          slen;
      int          hlen;
      int          cut;
      logic [31:0] plen;
      kind = long_subject ? 99 : $urandom_range(99);
      rand_bytes(PREFIX_BYTES);
      if (kind < 8) begin
         // subject length of zero or beyond one byte
         slen = ($urandom_range(1) == 0) ? 0 : $urandom_range(65535, 256);
         frame_buf.push_back(8'(slen >> 8));
         frame_buf.push_back(8'(slen));
         rand_bytes($urandom_range(4));
      end else if (kind < 15) begin
         rand_bytes($urandom_range(10));
      end else begin
         slen = long_subject ? 255 : $urandom_range(6, 1);
         hlen = ($urandom_range(99) < 40) ? 0 : $urandom_range(5, 1);
         plen = ($urandom_range(99) < 15) ? 0 : $urandom_range(8, 1);
         if (kind < 30) begin
            // truncated: any declared lengths, content capped, then cut short
            if ($urandom_range(1) == 1) begin
               slen = $urandom_range(255, 1);
               hlen = $urandom_range(65535);
               plen = $urandom;
            end
         end
         frame_buf.push_back(8'(slen >> 8));
         frame_buf.push_back(8'(slen));
         rand_bytes((slen > 12) && !long_subject ? 12 : slen);
         frame_buf.push_back(8'(hlen >> 8));
         frame_buf.push_back(8'(hlen));
         rand_bytes(hlen > 6 ? 6 : hlen);
         for (int i = 3; i >= 0; i--) frame_buf.push_back(plen[i*8 +: 8]);
         rand_bytes(plen > 8 ? 8 : int'(plen));
         if (kind < 30) begin
            cut = $urandom_range(frame_buf.size() - 1, 1);
            while (frame_buf.size() > cut) void'(frame_buf.pop_back());
         end else if (kind < 40) begin
            rand_bytes($urandom_range(3, 1));
         end
      end
      commit_frame();
   endtask

   task automatic drain();
      while (pending_bytes.size() != 0 || req_if.valid || expected_publish.size() != 0)
         @(posedge clock);
   endtask

   initial begin
      int start;
      req_if.valid   = 1'b0;
      req_if.in_byte = 8'd0;
      req_if.in_last = 1'b0;
      rsp_if.ready   = 1'b0;
      reset_parser();
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      for (int ph = 0; ph < 4; ph++) begin
         case (ph)
            0: begin sender_idle_pct = 0;  rsp_stall_pct = 0;  end
            1: begin sender_idle_pct = 69; rsp_stall_pct = 0;  end
            2: begin sender_idle_pct = 0;  rsp_stall_pct = 69; end
            default: begin sender_idle_pct = 7; rsp_stall_pct = 7; end
         endcase
         if (ph == 0) begin
            // shortest valid frame, empty headers and payload: status-only end
            frame_buf = {8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h00, 8'h01, 8'hFF,
                         8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00};
            commit_frame();
            // zero subject length, following byte swallowed
            frame_buf = {8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'hA5};
            commit_frame();
            // one-byte frame, too short
            frame_buf = {8'hFF};
            commit_frame();
         end
         start = bytes_queued;
         while (bytes_queued - start < BYTES_PER_PHASE) build_frame(1'b0);
         if (ph == 3) build_frame(1'b1);
         // sender holds off until every outstanding transaction is back
         drain();
      end

      repeat (8) @(posedge clock);
      $display("bytes in %0d, publish transactions checked %0d", bytes_in, beats_checked);
      $display("frames accepted as valid %0d, flagged malformed %0d", frames_ok, frames_bad);
      if (fail_count == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
